// File: design/assert_macros.svh
// Assertion macros shared by the list store RTL.
// Include with the bare file name; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is asserted (active low).
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion violated");
// Checked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion violated");
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/plst_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; the RTL modules import this package.
package plst_pkg;

    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 16;

    // Fixed field widths of the transfer payloads.
    localparam int CMD_W = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_REAR  = 3'd1,
        CMD_ADD_POS   = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_REAR  = 3'd4,
        CMD_REM_POS   = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cell_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] removed_value;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] length;
    } t_out_item;

endpackage

// File: design/plst_cell.sv
// One slot of the shifting register chain.
// Depends on plst_pkg for the control struct and widths.
module plst_cell import plst_pkg::*; (
    input  logic                     i_clk,
    input  logic [IDX_W-1:0]         i_index,
    input  t_cell_ctl                i_ctl,
    input  logic [ELEMENT_WIDTH-1:0] i_new,
    input  logic [ELEMENT_WIDTH-1:0] i_from_left,
    input  logic [ELEMENT_WIDTH-1:0] i_from_right,
    output logic [ELEMENT_WIDTH-1:0] o_value
);

    logic [ELEMENT_WIDTH-1:0] r_value;
    logic [ELEMENT_WIDTH-1:0] n_value;

    // Slots at and after the target index move: toward the rear on an
    // insert, toward the front on a remove.
    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            OP_INSERT: begin
                if (i_index == i_ctl.idx) begin
                    n_value = i_new;
                end else if (i_index > i_ctl.idx) begin
                    n_value = i_from_left;
                end
            end
            OP_REMOVE: begin
                if (i_index >= i_ctl.idx) begin
                    n_value = i_from_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: design/plst_decode.sv
// Command decoder: checks a command against the count and picks the chain
// operation, status and next count. Depends on plst_pkg.
module plst_decode import plst_pkg::*; (
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [POS_W-1:0] i_position,
    input  logic [CNT_W-1:0] i_count,
    output t_cell_ctl        o_ctl,
    output t_status          o_status,
    output logic [CNT_W-1:0] o_count
);

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             full;
    logic             empty;

    assign pos_x = CMP_W'(i_position);
    assign cnt_x = CMP_W'(i_count);
    assign full  = (i_count == CNT_W'(CAPACITY));
    assign empty = (i_count == '0);

    always_comb begin
        o_ctl.op  = OP_HOLD;
        o_ctl.idx = '0;
        o_status  = ST_OK;
        unique case (t_cmd'(i_cmd))
            CMD_ADD_FRONT: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.op = OP_INSERT;
                end
            end
            CMD_ADD_REAR: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.op  = OP_INSERT;
                    o_ctl.idx = IDX_W'(i_count);
                end
            end
            CMD_ADD_POS: begin
                // The range check wins over the full check.
                if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                    o_status = ST_RANGE;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.op  = OP_INSERT;
                    o_ctl.idx = IDX_W'(pos_x - CMP_W'(1));
                end
            end
            CMD_REM_FRONT: begin
                if (empty) begin
                    o_status = ST_UNDERFLOW;
                end else begin
                    o_ctl.op = OP_REMOVE;
                end
            end
            CMD_REM_REAR: begin
                if (empty) begin
                    o_status = ST_UNDERFLOW;
                end else begin
                    o_ctl.op  = OP_REMOVE;
                    o_ctl.idx = IDX_W'(i_count - CNT_W'(1));
                end
            end
            CMD_REM_POS: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.op  = OP_REMOVE;
                    o_ctl.idx = IDX_W'(pos_x - CMP_W'(1));
                end
            end
            default: begin
                o_ctl.op = OP_HOLD;
            end
        endcase
    end

    always_comb begin
        case (o_ctl.op)
            OP_INSERT: o_count = i_count + CNT_W'(1);
            OP_REMOVE: o_count = i_count - CNT_W'(1);
            default:   o_count = i_count;
        endcase
    end

endmodule

// File: design/positional_list_store.sv
// Top level of the positional list store: decoder, cell chain, result register.
// Depends on plst_pkg, plst_decode, plst_cell and assert_macros.svh.
//
// The block keeps an ordered list of up to CAPACITY values. Each command on
// the input channel (i_in_valid, o_in_stall, i_in_data) adds a value at the
// front, at the rear or before a one-based position, or removes the value at
// the front, at the rear or at a position. Every command produces exactly one
// result on the output channel (o_out_valid, i_out_stall, o_out_data) with the
// removed value (zero unless a remove succeeded), a status code and the count
// of stored elements after the command.
// A transfer happens at a rising edge where valid is high and stall is low.
// The list lives in a chain of identical cells, slot 0 at the front; all
// cells shift together in the cycle a command is accepted, which completes
// any insert or remove. The result is registered at the input transfer; one
// command per cycle is sustained unless the receiver stalls; the throughput is
// set by the single result register between the chain and the output channel.
// When the receiver stalls, the result register holds and the input channel
// stalls in turn, so no command is taken until the result is transferred.
// Synchronous reset empties the list and drops any pending result; the stored
// values themselves are not cleared and are never read while unoccupied.
`include "assert_macros.svh"

module positional_list_store import plst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic                     accept;
    t_cell_ctl                dec_ctl;
    t_status                  dec_status;
    logic [CNT_W-1:0]         dec_count;
    t_cell_ctl                cell_ctl;
    logic [ELEMENT_WIDTH-1:0] new_elem;
    logic [ELEMENT_WIDTH-1:0] cell_val [CAPACITY];

    // A new command may enter whenever the result register is empty or its
    // contents are transferred in this same cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    plst_decode u_decode (
        .i_cmd      (i_in_data.cmd),
        .i_position (i_in_data.position),
        .i_count    (r_count),
        .o_ctl      (dec_ctl),
        .o_status   (dec_status),
        .o_count    (dec_count)
    );

    // The chain only moves on an accepted command.
    always_comb begin
        if (accept) begin
            cell_ctl = dec_ctl;
        end else begin
            cell_ctl.op  = OP_HOLD;
            cell_ctl.idx = '0;
        end
    end

    assign new_elem = ELEMENT_WIDTH'(i_in_data.new_value);

    // Each cell sees its two neighbors; the ends of the chain read zero,
    // which no shift ever keeps in an occupied slot.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_val;
        logic [ELEMENT_WIDTH-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        plst_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctl        (cell_ctl),
            .i_new        (new_elem),
            .i_from_left  (left_val),
            .i_from_right (right_val),
            .o_value      (cell_val[g])
        );
    end

    // Result assembly: the removed value is read from the slot before it
    // shifts away.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_count     = r_count;
        if (accept) begin
            n_out_valid = 1'b1;
            n_count     = dec_count;
            n_out.status = dec_status;
            n_out.length = LEN_W'(dec_count);
            if (dec_ctl.op == OP_REMOVE) begin
                n_out.removed_value = VAL_W'(cell_val[dec_ctl.idx]);
            end else begin
                n_out.removed_value = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The count never runs past the number of cells.
    `ASSERT_SYNC(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    // No result is pending in the cycle after reset.
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid)
    // A successful insert grows the list by exactly one element.
    `ASSERT_SYNC(a_insert_grows, i_clk, i_rst_n, (accept && dec_ctl.op == OP_INSERT) |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
    // A full report is only given while the list stays at capacity.
    `ASSERT_SYNC(a_full_at_cap, i_clk, i_rst_n, (r_out_valid && r_out.status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))

endmodule
